### rtl/core/i2cs_pkg.sv
`default_nettype none

package i2cs_pkg;

    localparam int WRITE_DEPTH = 16;
    localparam int WADDR_W     = $clog2(WRITE_DEPTH);
    localparam int WPOS_W      = 5;

    typedef enum logic [1:0] {
        FN_LOAD  = 2'd0,
        FN_START = 2'd1,
        FN_EVENT = 2'd2
    } func_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_START   = 4'd1,
        PH_WRITE   = 4'd2,
        PH_RESTART = 4'd3,
        PH_ACK     = 4'd4,
        PH_READ    = 4'd5,
        PH_NACK    = 4'd6,
        PH_STOP    = 4'd7,
        PH_ERROR   = 4'd8
    } phase_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_START   = 3'd1,
        ACT_TX      = 3'd2,
        ACT_RESTART = 3'd3,
        ACT_RCV     = 3'd4,
        ACT_ACK     = 3'd5,
        ACT_NACK    = 3'd6,
        ACT_STOP    = 3'd7
    } action_t;

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] wr_index;
        logic [7:0] wr_byte;
        logic [6:0] target_addr;
        logic [4:0] write_count;
        logic [7:0] read_count;
        logic       ack_missing;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] tx_byte;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic [7:0] rx_position;
        logic       done_res;
        logic       success;
    } res_t;

    typedef struct packed {
        logic               we;
        logic [WADDR_W-1:0] addr;
        logic [7:0]         data;
    } wr_req_t;

endpackage

`default_nettype wire

### rtl/core/i2c_master_write_read_sequencer.sv
// Channel  Handshake            Payload
// in       in_valid / in_stall  func wr_index wr_byte target_addr write_count
//                               read_count ack_missing rx_byte
// out      out_valid/out_stall  action tx_byte rx_valid rx_data rx_position
//                               done_res success
//
// One item per cycle sustained while out_stall stays low.
// Item goes into an input register, the phase update and result are
// formed in one pass and land in the result register.
// rst_n clears phase, counters and both handshake stages; the write store
// is not cleared.
// out_stall backs up into in_stall only when both stages are full.
`default_nettype none

module i2c_master_write_read_sequencer
    import i2cs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] func,
    input  wire logic [3:0] wr_index,
    input  wire logic [7:0] wr_byte,
    input  wire logic [6:0] target_addr,
    input  wire logic [4:0] write_count,
    input  wire logic [7:0] read_count,
    input  wire logic       ack_missing,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      action,
    output logic [7:0]      tx_byte,
    output logic            rx_valid,
    output logic [7:0]      rx_data,
    output logic [7:0]      rx_position,
    output logic            done_res,
    output logic            success
);

    logic               in_full_reg, in_full_next;
    item_t              item_reg;
    logic               out_full_reg, out_full_next;
    res_t               res_reg;
    res_t               res;
    wr_req_t            wr_req;
    logic [WADDR_W-1:0] store_addr;
    logic [7:0]         store_data;
    logic               advance;
    logic               accept;

    assign advance       = in_full_reg && (!out_full_reg || !out_stall);
    assign in_stall      = in_full_reg && !advance;
    assign accept        = in_valid && !in_stall;
    assign in_full_next  = accept || (in_full_reg && !advance);
    assign out_full_next = advance || (out_full_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg  <= in_full_next;
            out_full_reg <= out_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= '{func:        func,
                          wr_index:    wr_index,
                          wr_byte:     wr_byte,
                          target_addr: target_addr,
                          write_count: write_count,
                          read_count:  read_count,
                          ack_missing: ack_missing,
                          rx_byte:     rx_byte};
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    i2cs_wstore u_wstore (
        .clk     (clk),
        .wr_req  (wr_req),
        .rd_addr (store_addr),
        .rd_data (store_data)
    );

    i2cs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (advance),
        .item       (item_reg),
        .store_data (store_data),
        .store_addr (store_addr),
        .wr_req     (wr_req),
        .res        (res)
    );

    assign out_valid   = out_full_reg;
    assign action      = res_reg.action;
    assign tx_byte     = res_reg.tx_byte;
    assign rx_valid    = res_reg.rx_valid;
    assign rx_data     = res_reg.rx_data;
    assign rx_position = res_reg.rx_position;
    assign done_res    = res_reg.done_res;
    assign success     = res_reg.success;

endmodule

`default_nettype wire

### rtl/core/i2cs_wstore.sv
`default_nettype none

module i2cs_wstore
    import i2cs_pkg::*;
(
    input  wire logic               clk,
    input  wire wr_req_t            wr_req,
    input  wire logic [WADDR_W-1:0] rd_addr,
    output logic [7:0]              rd_data
);

    logic [7:0] store_reg [WRITE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_req.we)
        begin
            store_reg[wr_req.addr] <= wr_req.data;
        end
    end

    assign rd_data = store_reg[rd_addr];

endmodule

`default_nettype wire

### rtl/core/i2cs_ctrl.sv
`default_nettype none

module i2cs_ctrl
    import i2cs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step_en,
    input  wire item_t              item,
    input  wire logic [7:0]         store_data,
    output logic [WADDR_W-1:0]      store_addr,
    output wr_req_t                 wr_req,
    output res_t                    res
);

    phase_t            phase_reg, phase_next;
    logic [WPOS_W-1:0] write_pos_reg, write_pos_next;
    logic [7:0]        read_pos_reg, read_pos_next;
    logic [6:0]        slave_addr_reg, slave_addr_next;
    logic [WPOS_W-1:0] writes_wanted_reg, writes_wanted_next;
    logic [7:0]        reads_wanted_reg, reads_wanted_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            write_pos_reg     <= '0;
            read_pos_reg      <= '0;
            slave_addr_reg    <= '0;
            writes_wanted_reg <= '0;
            reads_wanted_reg  <= '0;
        end
        else if (step_en)
        begin
            phase_reg         <= phase_next;
            write_pos_reg     <= write_pos_next;
            read_pos_reg      <= read_pos_next;
            slave_addr_reg    <= slave_addr_next;
            writes_wanted_reg <= writes_wanted_next;
            reads_wanted_reg  <= reads_wanted_next;
        end
    end

    assign store_addr = write_pos_reg[WADDR_W-1:0];

    always_comb
    begin
        logic [7:0]        addr_byte;
        logic [WPOS_W-1:0] wc;
        logic [7:0]        rc;
        logic [7:0]        rpos_inc;

        addr_byte = {slave_addr_reg, 1'b0};
        wc        = item.write_count;
        rc        = item.read_count;
        rpos_inc  = read_pos_reg + 8'd1;

        phase_next         = phase_reg;
        write_pos_next     = write_pos_reg;
        read_pos_next      = read_pos_reg;
        slave_addr_next    = slave_addr_reg;
        writes_wanted_next = writes_wanted_reg;
        reads_wanted_next  = reads_wanted_reg;
        res                = '0;
        wr_req.we          = 1'b0;
        wr_req.addr        = item.wr_index[WADDR_W-1:0];
        wr_req.data        = item.wr_byte;

        unique case (item.func)
            FN_LOAD:
            begin
                wr_req.we = step_en && (int'(item.wr_index) < WRITE_DEPTH);
            end
            FN_START:
            begin
                if (int'(wc) > WRITE_DEPTH)
                begin
                    wc = WPOS_W'(WRITE_DEPTH);
                end
                // no bytes either way: do a one-byte read
                if (wc == '0 && rc == '0)
                begin
                    rc = 8'd1;
                end
                slave_addr_next    = item.target_addr;
                writes_wanted_next = wc;
                reads_wanted_next  = rc;
                write_pos_next     = '0;
                read_pos_next      = '0;
                phase_next         = PH_START;
                res.action         = ACT_START;
            end
            FN_EVENT:
            begin
                unique case (phase_reg)
                    PH_START:
                    begin
                        write_pos_next = '0;
                        read_pos_next  = '0;
                        res.action     = ACT_TX;
                        if (writes_wanted_reg != '0)
                        begin
                            phase_next  = PH_WRITE;
                            res.tx_byte = addr_byte;
                        end
                        else
                        begin
                            phase_next  = PH_ACK;
                            res.tx_byte = addr_byte | 8'd1;
                        end
                    end
                    PH_WRITE:
                    begin
                        priority if (item.ack_missing)
                        begin
                            phase_next   = PH_ERROR;
                            res.done_res = 1'b1;
                        end
                        else if (write_pos_reg < writes_wanted_reg)
                        begin
                            res.action     = ACT_TX;
                            res.tx_byte    = store_data;
                            write_pos_next = write_pos_reg + WPOS_W'(1);
                        end
                        else if (reads_wanted_reg != '0)
                        begin
                            phase_next = PH_RESTART;
                            res.action = ACT_RESTART;
                        end
                        else
                        begin
                            phase_next = PH_STOP;
                            res.action = ACT_STOP;
                        end
                    end
                    PH_RESTART:
                    begin
                        phase_next  = PH_ACK;
                        res.action  = ACT_TX;
                        res.tx_byte = addr_byte | 8'd1;
                    end
                    PH_ACK:
                    begin
                        phase_next = PH_READ;
                        res.action = ACT_RCV;
                    end
                    PH_READ:
                    begin
                        if (item.ack_missing)
                        begin
                            phase_next   = PH_ERROR;
                            res.done_res = 1'b1;
                        end
                        else
                        begin
                            res.rx_valid    = 1'b1;
                            res.rx_data     = item.rx_byte;
                            res.rx_position = read_pos_reg;
                            read_pos_next   = rpos_inc;
                            if (rpos_inc == reads_wanted_reg)
                            begin
                                phase_next = PH_NACK;
                                res.action = ACT_NACK;
                            end
                            else
                            begin
                                phase_next = PH_ACK;
                                res.action = ACT_ACK;
                            end
                        end
                    end
                    PH_NACK:
                    begin
                        phase_next = PH_STOP;
                        res.action = ACT_STOP;
                    end
                    PH_STOP:
                    begin
                        phase_next   = PH_IDLE;
                        res.done_res = 1'b1;
                        res.success  = 1'b1;
                    end
                    default:
                    begin
                        // idle or error: the event itself is an error
                        phase_next   = PH_ERROR;
                        res.done_res = 1'b1;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/i2cs_checker.sv
`default_nettype none

module i2cs_checker
    import i2cs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_stall,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic [2:0] action,
    input  wire logic [7:0] tx_byte,
    input  wire logic       rx_valid,
    input  wire logic       done_res,
    input  wire logic       success
);

    // a successful finish is always a finish
    a_success_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && success |-> done_res)
        else $error("success without done_res");

    // received bytes only come with an ack or nack decision
    a_rx_action: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rx_valid |-> (action == ACT_ACK || action == ACT_NACK))
        else $error("rx byte without ack/nack");

    // tx byte only carries data on a transmit
    a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action != ACT_TX |-> tx_byte == 8'd0)
        else $error("tx_byte set outside transmit");

    // input held off only while output is backed up
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with free output");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(action) && $stable(tx_byte))
        else $error("stalled item changed");

endmodule

bind i2c_master_write_read_sequencer i2cs_checker u_i2cs_checker (.*);

`default_nettype wire

### tb/i2c_master_write_read_sequencer_tb.sv
module i2c_master_write_read_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cs_pkg::*;

    localparam logic [1:0] FN_UNUSED   = 2'd3;
    localparam int         QUIET_LIMIT = 1000;

    class i2c_txn_scoreboard;
        phase_t     phase;
        logic [7:0] store [WRITE_DEPTH];
        logic [4:0] write_pos;
        logic [7:0] read_pos;
        logic [6:0] slave_addr;
        logic [4:0] writes_wanted;
        logic [7:0] reads_wanted;
        res_t       pending [$];
        int         errors;

        function new();
            phase         = PH_IDLE;
            write_pos     = '0;
            read_pos      = '0;
            slave_addr    = '0;
            writes_wanted = '0;
            reads_wanted  = '0;
            errors        = 0;
        endfunction

        // bus action and delivered byte for one item; advances the shadow phase
        function res_t next_bus_step(item_t it);
            res_t       r;
            logic [7:0] addr_byte;
            logic [4:0] wc;
            logic [7:0] rc;
            r = '0;
            addr_byte = {slave_addr, 1'b0};
            case (it.func)
                FN_LOAD:
                begin
                    store[it.wr_index] = it.wr_byte;
                end
                FN_START:
                begin
                    wc = (it.write_count > WRITE_DEPTH) ? 5'(WRITE_DEPTH) : it.write_count;
                    rc = it.read_count;
                    // nothing to write and nothing to read: one-byte read
                    if (wc == '0 && rc == '0)
                        rc = 8'd1;
                    slave_addr    = it.target_addr;
                    writes_wanted = wc;
                    reads_wanted  = rc;
                    write_pos     = '0;
                    read_pos      = '0;
                    phase         = PH_START;
                    r.action      = ACT_START;
                end
                FN_EVENT:
                begin
                    case (phase)
                        PH_START:
                        begin
                            write_pos = '0;
                            read_pos  = '0;
                            r.action  = ACT_TX;
                            if (writes_wanted != '0)
                            begin
                                phase     = PH_WRITE;
                                r.tx_byte = addr_byte;
                            end
                            else
                            begin
                                phase     = PH_ACK;
                                r.tx_byte = addr_byte | 8'd1;
                            end
                        end
                        PH_WRITE:
                        begin
                            if (it.ack_missing)
                            begin
                                phase      = PH_ERROR;
                                r.done_res = 1'b1;
                            end
                            else if (write_pos < writes_wanted)
                            begin
                                r.action  = ACT_TX;
                                r.tx_byte = store[write_pos[3:0]];
                                write_pos = write_pos + 5'd1;
                            end
                            else if (reads_wanted != '0)
                            begin
                                phase    = PH_RESTART;
                                r.action = ACT_RESTART;
                            end
                            else
                            begin
                                phase    = PH_STOP;
                                r.action = ACT_STOP;
                            end
                        end
                        PH_RESTART:
                        begin
                            phase     = PH_ACK;
                            r.action  = ACT_TX;
                            r.tx_byte = addr_byte | 8'd1;
                        end
                        PH_ACK:
                        begin
                            phase    = PH_READ;
                            r.action = ACT_RCV;
                        end
                        PH_READ:
                        begin
                            if (it.ack_missing)
                            begin
                                phase      = PH_ERROR;
                                r.done_res = 1'b1;
                            end
                            else
                            begin
                                r.rx_valid    = 1'b1;
                                r.rx_data     = it.rx_byte;
                                r.rx_position = read_pos;
                                read_pos      = read_pos + 8'd1;
                                if (read_pos == reads_wanted)
                                begin
                                    phase    = PH_NACK;
                                    r.action = ACT_NACK;
                                end
                                else
                                begin
                                    phase    = PH_ACK;
                                    r.action = ACT_ACK;
                                end
                            end
                        end
                        PH_NACK:
                        begin
                            phase    = PH_STOP;
                            r.action = ACT_STOP;
                        end
                        PH_STOP:
                        begin
                            phase      = PH_IDLE;
                            r.done_res = 1'b1;
                            r.success  = 1'b1;
                        end
                        default:
                        begin
                            // event while idle or after an error
                            phase      = PH_ERROR;
                            r.done_res = 1'b1;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
            return r;
        endfunction

        function void note_item(item_t it);
            pending.push_back(next_bus_step(it));
        endfunction

        function void check_result(res_t got);
            res_t exp;
            if (pending.size() == 0)
            begin
                if (errors < 10)
                    $display("%0t: result with none expected: act %0d tx %02h rxv %0b rxd %02h",
                             $realtime, got.action, got.tx_byte, got.rx_valid, got.rx_data);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.action !== exp.action || got.tx_byte !== exp.tx_byte ||
                got.rx_valid !== exp.rx_valid || got.rx_data !== exp.rx_data ||
                got.rx_position !== exp.rx_position || got.done_res !== exp.done_res ||
                got.success !== exp.success)
            begin
                if (errors < 10)
                begin
                    $write("%0t: mismatch (exp/got) act %0d/%0d tx %02h/%02h rxv %0b/%0b",
                           $realtime, exp.action, got.action, exp.tx_byte, got.tx_byte,
                           exp.rx_valid, got.rx_valid);
                    $display(" rxd %02h/%02h pos %0d/%0d done %0b/%0b ok %0b/%0b",
                             exp.rx_data, got.rx_data, exp.rx_position, got.rx_position,
                             exp.done_res, got.done_res, exp.success, got.success);
                end
                errors++;
            end
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       out_stall = 1'b0;
    item_t      in_item   = '0;
    logic       in_stall;
    logic       out_valid;
    logic [2:0] action;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic [7:0] rx_position;
    logic       done_res;
    logic       success;
    res_t       dut_res;

    i2c_txn_scoreboard sb;
    item_t             stim [$];
    logic [15:0]       loaded       = '0;
    bit                tx_gaps      = 1'b0;
    bit                rx_gaps      = 1'b0;
    bit                long_hold_req = 1'b0;
    int                hold_left    = 0;
    int                gap_left     = 0;
    int                quiet_cycles = 0;

    assign dut_res = {action, tx_byte, rx_valid, rx_data, rx_position, done_res, success};

    i2c_master_write_read_sequencer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (in_item.func),
        .wr_index    (in_item.wr_index),
        .wr_byte     (in_item.wr_byte),
        .target_addr (in_item.target_addr),
        .write_count (in_item.write_count),
        .read_count  (in_item.read_count),
        .ack_missing (in_item.ack_missing),
        .rx_byte     (in_item.rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .action      (action),
        .tx_byte     (tx_byte),
        .rx_valid    (rx_valid),
        .rx_data     (rx_data),
        .rx_position (rx_position),
        .done_res    (done_res),
        .success     (success)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: one long hold on request, random stall bursts otherwise when rx_gaps is set
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            out_stall <= 1'b1;
            hold_left = 80;
        end
        else if (gap_left > 0)
        begin
            out_stall <= 1'b1;
            gap_left = gap_left - 1;
        end
        else if (rx_gaps && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            gap_left = $urandom_range(1, 8) - 1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_item(in_item);
            if (out_valid && !out_stall)
                sb.check_result(dut_res);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        @(posedge rst_n);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("i2c_master_write_read_sequencer_tb NOT OK");
        $finish;
    end

    function automatic item_t noise_fields();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(item_t)-1:0];
    endfunction

    function automatic void push_item(item_t it);
        stim.push_back(it);
        if (it.func == FN_LOAD)
            loaded[it.wr_index] = 1'b1;
    endfunction

    function automatic void push_load(logic [3:0] idx, logic [7:0] data);
        item_t it;
        it          = noise_fields();
        it.func     = FN_LOAD;
        it.wr_index = idx;
        it.wr_byte  = data;
        push_item(it);
    endfunction

    function automatic void push_start(logic [6:0] addr, logic [4:0] wc, logic [7:0] rc);
        item_t it;
        it             = noise_fields();
        it.func        = FN_START;
        it.target_addr = addr;
        it.write_count = wc;
        it.read_count  = rc;
        push_item(it);
    endfunction

    function automatic void push_event(logic ack, logic [7:0] rxb);
        item_t it;
        it             = noise_fields();
        it.func        = FN_EVENT;
        it.ack_missing = ack;
        it.rx_byte     = rxb;
        push_item(it);
    endfunction

    function automatic void push_unused_func();
        item_t it;
        it      = noise_fields();
        it.func = FN_UNUSED;
        push_item(it);
    endfunction

    // one write-then-read transaction, sometimes cut short or sprinkled with noise
    function automatic void add_transaction();
        int v;
        int w;
        int r;
        int weff;
        int reff;
        int n;
        int m;
        bit dirty;
        v = $urandom_range(0, 99);
        w = (v < 70) ? $urandom_range(0, 4) : (v < 92) ? $urandom_range(5, 16)
                                                       : $urandom_range(17, 31);
        v = $urandom_range(0, 99);
        r = (v < 45) ? $urandom_range(0, 3) : (v < 88) ? $urandom_range(4, 12)
          : (v < 98) ? $urandom_range(13, 64) : $urandom_range(200, 255);
        weff = (w > WRITE_DEPTH) ? WRITE_DEPTH : w;
        reff = (weff == 0 && r == 0) ? 1 : r;
        // never send a store entry that was not loaded
        for (int i = 0; i < weff; i++)
            if (!loaded[i])
                push_load(4'(i), 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0)
            push_load(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
        dirty = (reff < 64) && ($urandom_range(0, 3) == 0);
        push_start(7'($urandom_range(0, 127)), 5'(w), 8'(r));
        n = 1 + ((weff > 0) ? weff + 1 : 0)
              + ((reff > 0) ? ((weff > 0) ? 1 : 0) + 2 * reff + 1 : 0) + 1;
        m = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n - 1) : n;
        for (int k = 0; k < m; k++)
        begin
            if ($urandom_range(0, 24) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    push_load(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
                else
                    push_unused_func();
            end
            // clean runs: ack_missing only on the first and last event, where it is ignored
            if (dirty)
                push_event($urandom_range(0, 9) == 0, 8'($urandom_range(0, 255)));
            else
                push_event((k == 0 || k == n - 1) && $urandom_range(0, 1) == 1,
                           8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 7) == 0)
            push_event(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endfunction

    task automatic send_items();
        item_t it;
        while (stim.size() != 0)
        begin
            it = stim.pop_front();
            if (tx_gaps && $urandom_range(0, 5) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8))
                    @(posedge clk);
            end
            in_valid <= 1'b1;
            in_item  <= it;
            do
                @(posedge clk);
            while (in_stall);
        end
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (sb.pending.size() != 0);
    endtask

    initial
    begin
        sb = new();
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        push_event(1'b0, 8'h00);          // event while idle
        push_event(1'b1, 8'hFF);          // event after error
        push_unused_func();
        push_load(4'd0, 8'h00);
        push_load(4'd1, 8'hFF);
        push_load(4'd2, 8'h5A);
        push_load(4'd15, 8'hA5);
        // both counts zero: single-byte read, ack_missing ignored at start and stop
        push_start(7'h7F, 5'd0, 8'd0);
        for (int k = 0; k < 5; k++)
            push_event(k == 0 || k == 4, 8'hFF);
        // missing ack in the write phase
        push_start(7'h2A, 5'd1, 8'd2);
        push_event(1'b0, 8'h00);
        push_event(1'b1, 8'h00);
        // start while busy, then missing ack in the read phase
        push_start(7'h55, 5'd3, 8'd255);
        push_event(1'b0, 8'h00);
        push_event(1'b0, 8'h00);
        push_start(7'h01, 5'd0, 8'd1);
        push_event(1'b0, 8'h00);
        push_event(1'b0, 8'h00);
        push_event(1'b1, 8'hC3);
        send_items();
        wait_drained();

        long_hold_req = 1'b1;
        while (stim.size() < 800)
            add_transaction();
        send_items();
        wait_drained();

        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        while (stim.size() < 350)
            add_transaction();
        send_items();
        wait_drained();
        repeat (10)
            @(posedge clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("i2c_master_write_read_sequencer_tb OK");
        else
            $display("i2c_master_write_read_sequencer_tb NOT OK");
        $finish;
    end

endmodule
